// ===== rtl/core/distance_vector_relax_core_defines.svh =====
// Assertion macros shared by the distance vector relax core.
// Depends on a clock named clock and a reset named reset in the including scope.
`ifndef DISTANCE_VECTOR_RELAX_CORE_DEFINES_SVH
`define DISTANCE_VECTOR_RELAX_CORE_DEFINES_SVH

// same-cycle implication
`define DVR_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DVR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/dvr_pkg.sv =====
// Package for the distance vector relax core: sizes, request codes, item and entry types.
// No dependencies.
`default_nettype none

package dvr_pkg;

   localparam int MAX_NODES  = 64;
   localparam int NODE_BITS  = $clog2(MAX_NODES);
   localparam int ID_BITS    = 6;
   localparam int COST_BITS  = 16;
   localparam int ROUTE_BITS = COST_BITS + ID_BITS;

   localparam logic [COST_BITS-1:0] COST_MAX = '1;

   typedef enum logic {
      REQ_LOAD    = 1'b0,
      REQ_ELEMENT = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type         kind;
      logic [ID_BITS-1:0]   sender;
      logic [ID_BITS-1:0]   dest_index;
      logic [COST_BITS-1:0] offered_cost;
      logic                 cost_known;
      logic [ID_BITS-1:0]   load_next_hop;
      logic                 last_element;
   } dvr_item_type;

   typedef struct packed {
      logic                 known;
      logic [COST_BITS-1:0] cost;
      logic [ID_BITS-1:0]   hop;
   } dvr_entry_type;

   typedef struct packed {
      dvr_entry_type entry;
      logic          changed;
   } dvr_result_type;

endpackage

`default_nettype wire

// ===== rtl/core/dvr_if.sv =====
// Request and response channel interfaces of the distance vector relax core.
// Depends on dvr_pkg.
`default_nettype none

interface dvr_req_if import dvr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [ID_BITS-1:0]   sender;
   logic [ID_BITS-1:0]   dest_index;
   logic [COST_BITS-1:0] offered_cost;
   logic                 cost_known;
   logic [ID_BITS-1:0]   load_next_hop;
   logic                 last_element;

   modport source (
      output valid, req_type, sender, dest_index, offered_cost, cost_known,
             load_next_hop, last_element,
      input  ready
   );
   modport sink (
      input  valid, req_type, sender, dest_index, offered_cost, cost_known,
             load_next_hop, last_element,
      output ready
   );
endinterface

interface dvr_rsp_if import dvr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ID_BITS-1:0]   out_index;
   logic [COST_BITS-1:0] out_cost;
   logic                 out_known;
   logic [ID_BITS-1:0]   out_next_hop;
   logic                 changed;
   logic                 out_last;

   modport source (
      output valid, out_index, out_cost, out_known, out_next_hop, changed, out_last,
      input  ready
   );
   modport sink (
      input  valid, out_index, out_cost, out_known, out_next_hop, changed, out_last,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/dvr_route_ram.sv =====
// Route table memory: one write port, two registered read ports.
// No dependencies.
`default_nettype none

module dvr_route_ram #(
   parameter int Depth = 64,
   parameter int Width = 22
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr_a,
   input  logic [$clog2(Depth)-1:0] rd_addr_b,
   output logic [Width-1:0]         rd_data_a,
   output logic [Width-1:0]         rd_data_b
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_a_ff;
   logic [Width-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dvr_relax_unit.sv =====
// Relaxation logic: saturating cost sum, compare, and new entry selection.
// Depends on dvr_pkg.
`default_nettype none

module dvr_relax_unit import dvr_pkg::*; (
   input  dvr_item_type   item,
   input  dvr_entry_type  dst_entry,
   input  dvr_entry_type  snd_entry,
   output dvr_result_type result
);

   logic [COST_BITS:0]   sum_wide;
   logic [COST_BITS-1:0] sum_sat;
   logic                 better;

   assign sum_wide = {1'b0, item.offered_cost} + {1'b0, snd_entry.cost};
   assign sum_sat  = sum_wide[COST_BITS] ? COST_MAX : sum_wide[COST_BITS-1:0];
   assign better   = item.cost_known && snd_entry.known &&
                     (!dst_entry.known || (sum_sat < dst_entry.cost));

   always_comb begin
      result.entry   = dst_entry;
      result.changed = 1'b0;
      unique case (item.kind)
         REQ_LOAD: begin
            result.entry.known = item.cost_known;
            result.entry.cost  = item.offered_cost;
            result.entry.hop   = item.load_next_hop;
            result.changed     = 1'b1;
         end
         REQ_ELEMENT: begin
            if (better) begin
               result.entry.known = 1'b1;
               result.entry.cost  = sum_sat;
               result.entry.hop   = snd_entry.hop;
               result.changed     = 1'b1;
            end
         end
         default: begin
            result.changed = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/distance_vector_relax_core.sv =====
// An accepted transfer goes to ST_EXEC, where it is relaxed and its response is
// registered. No new item is taken while one is in ST_EXEC, nor while a response
// is stalled: the route memory is read at accept and written back in ST_EXEC.
// Reset: clears the known flags of all 64 entries at once, the sender latch, the
// mid-vector flag and the response valid; costs and hops stay as they are.
// Depends on dvr_pkg, dvr_if, dvr_route_ram, dvr_relax_unit and the defines header.
`default_nettype none

`include "distance_vector_relax_core_defines.svh"

module distance_vector_relax_core import dvr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   dvr_req_if.sink      req_ch,
   dvr_rsp_if.source    rsp_ch
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [ID_BITS-1:0]   index;
      logic [COST_BITS-1:0] cost;
      logic                 known;
      logic [ID_BITS-1:0]   hop;
      logic                 changed;
      logic                 last;
   } rsp_type;

   state_type            state_ff, state_in;
   dvr_item_type         item_ff, item_in;
   logic [MAX_NODES-1:0] known_ff;
   dvr_entry_type        latch_ff, latch_in;
   logic                 mid_ff, mid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic                  exec;
   logic                  is_element;
   logic [NODE_BITS-1:0]  dst_idx;
   logic [NODE_BITS-1:0]  snd_idx;
   logic [ROUTE_BITS-1:0] rd_dst;
   logic [ROUTE_BITS-1:0] rd_snd;
   dvr_entry_type         dst_entry;
   dvr_entry_type         fresh_snd;
   dvr_entry_type         snd_entry;
   dvr_result_type        relax;
   logic                  wr_en;

   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign exec         = (state_ff == ST_EXEC);
   assign is_element   = (item_ff.kind == REQ_ELEMENT);

   always_comb begin
      item_in = item_ff;
      if (req_accept) begin
         item_in.kind          = req_kind_type'(req_ch.req_type);
         item_in.sender        = req_ch.sender;
         item_in.dest_index    = req_ch.dest_index;
         item_in.offered_cost  = req_ch.offered_cost;
         item_in.cost_known    = req_ch.cost_known;
         item_in.load_next_hop = req_ch.load_next_hop;
         item_in.last_element  = req_ch.last_element;
      end
   end

   assign dst_idx = item_ff.dest_index[NODE_BITS-1:0];
   assign snd_idx = item_ff.sender[NODE_BITS-1:0];

   dvr_route_ram #(
      .Depth (MAX_NODES),
      .Width (ROUTE_BITS)
   ) u_route_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (dst_idx),
      .wr_data   ({relax.entry.cost, relax.entry.hop}),
      .rd_en     (req_accept),
      .rd_addr_a (req_ch.dest_index[NODE_BITS-1:0]),
      .rd_addr_b (req_ch.sender[NODE_BITS-1:0]),
      .rd_data_a (rd_dst),
      .rd_data_b (rd_snd)
   );

   assign dst_entry.known = known_ff[dst_idx];
   assign dst_entry.cost  = rd_dst[ROUTE_BITS-1:ID_BITS];
   assign dst_entry.hop   = rd_dst[ID_BITS-1:0];
   assign fresh_snd.known = known_ff[snd_idx];
   assign fresh_snd.cost  = rd_snd[ROUTE_BITS-1:ID_BITS];
   assign fresh_snd.hop   = rd_snd[ID_BITS-1:0];
   assign snd_entry       = mid_ff ? latch_ff : fresh_snd;

   dvr_relax_unit u_relax_unit (
      .item      (item_ff),
      .dst_entry (dst_entry),
      .snd_entry (snd_entry),
      .result    (relax)
   );

   assign wr_en = exec && relax.changed;

   always_comb begin
      latch_in = latch_ff;
      mid_in   = mid_ff;
      if (exec && is_element) begin
         if (!mid_ff) begin
            latch_in = fresh_snd;
         end
         mid_in = !item_ff.last_element;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
            end
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in            = ST_IDLE;
            rsp_valid_in        = 1'b1;
            rsp_data_in.index   = item_ff.dest_index;
            rsp_data_in.known   = relax.entry.known;
            rsp_data_in.cost    = relax.entry.known ? relax.entry.cost : '0;
            rsp_data_in.hop     = relax.entry.known ? relax.entry.hop : '0;
            rsp_data_in.changed = relax.changed;
            rsp_data_in.last    = item_ff.last_element;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= '0;
         latch_ff <= '0;
         mid_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            known_ff[dst_idx] <= relax.entry.known;
         end
         latch_ff <= latch_in;
         mid_ff   <= mid_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_index    = rsp_data_ff.index;
   assign rsp_ch.out_cost     = rsp_data_ff.cost;
   assign rsp_ch.out_known    = rsp_data_ff.known;
   assign rsp_ch.out_next_hop = rsp_data_ff.hop;
   assign rsp_ch.changed      = rsp_data_ff.changed;
   assign rsp_ch.out_last     = rsp_data_ff.last;

   `DVR_ASSERT_NEXT(a_accept_exec, req_accept, state_ff == ST_EXEC, "accepted transfer did not enter execute")
   `DVR_ASSERT_NEXT(a_exec_rsp, exec, rsp_valid_ff, "execute cycle did not produce a response")
   `DVR_ASSERT_IMPL(a_unknown_zero, rsp_valid_ff && !rsp_data_ff.known, (rsp_data_ff.cost == '0) && (rsp_data_ff.hop == '0), "unknown entry exposes cost or hop")
   `DVR_ASSERT_IMPL(a_relax_known, exec && is_element && relax.changed, relax.entry.known, "relaxed entry left unknown")

endmodule

`default_nettype wire

// ===== tb/sv/tb_distance_vector_relax_core.sv =====
// Self-checking testbench for distance_vector_relax_core: directed route table cases,
// then random distance vectors, checked against an in-bench route relaxation predictor.
// Depends on dvr_pkg, dvr_if and the RTL of distance_vector_relax_core.
`default_nettype none

module tb_distance_vector_relax_core import dvr_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOTAL_ITEMS    = 1900;
   localparam int CALM_ITEMS     = 200;
   localparam int PRESSURE_AT    = 900;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 4;

   typedef struct packed {
      logic [ID_BITS-1:0]   index;
      logic [COST_BITS-1:0] cost;
      logic                 known;
      logic [ID_BITS-1:0]   hop;
      logic                 changed;
      logic                 last;
   } route_report_type;

   typedef struct {
      dvr_item_type     item;
      bit               typed;
      route_report_type want;
   } plan_row_type;

   logic clock;
   logic reset;

   dvr_req_if req_ch();
   dvr_rsp_if rsp_ch();

   distance_vector_relax_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bit [COST_BITS-1:0] tbl_cost  [MAX_NODES];
   bit                 tbl_known [MAX_NODES];
   bit [ID_BITS-1:0]   tbl_hop   [MAX_NODES];
   bit [COST_BITS-1:0] latch_cost;
   bit                 latch_known;
   bit [ID_BITS-1:0]   latch_hop;
   bit                 in_vector;

   route_report_type pending_reports[$];
   int               fault_count;
   int               sent_count;
   bit               calm;

   function automatic route_report_type relax_route(dvr_item_type it);
      route_report_type     r;
      logic [COST_BITS:0]   wide_sum;
      logic [COST_BITS-1:0] sum;
      int                   d;
      int                   s;
      bit                   chg;
      d   = it.dest_index % MAX_NODES;
      s   = it.sender % MAX_NODES;
      chg = 1'b0;
      if (it.kind == REQ_LOAD) begin
         tbl_cost[d]  = it.offered_cost;
         tbl_known[d] = it.cost_known;
         tbl_hop[d]   = it.load_next_hop;
         chg = 1'b1;
      end else begin
         if (!in_vector) begin
            latch_known = tbl_known[s];
            latch_cost  = tbl_cost[s];
            latch_hop   = tbl_hop[s];
         end
         if (it.cost_known && latch_known) begin
            wide_sum = {1'b0, it.offered_cost} + {1'b0, latch_cost};
            sum = wide_sum[COST_BITS] ? COST_MAX : wide_sum[COST_BITS-1:0];
            if (!tbl_known[d] || sum < tbl_cost[d]) begin
               tbl_cost[d]  = sum;
               tbl_known[d] = 1'b1;
               tbl_hop[d]   = latch_hop;
               chg = 1'b1;
            end
         end
         in_vector = !it.last_element;
      end
      r.index   = it.dest_index;
      r.known   = tbl_known[d];
      r.cost    = tbl_known[d] ? tbl_cost[d] : '0;
      r.hop     = tbl_known[d] ? tbl_hop[d] : '0;
      r.changed = chg;
      r.last    = it.last_element;
      return r;
   endfunction

   function automatic dvr_item_type load_item(int dst, int cost, bit known, int hop, bit last);
      dvr_item_type it;
      it.kind          = REQ_LOAD;
      it.sender        = ID_BITS'($urandom);
      it.dest_index    = ID_BITS'(dst);
      it.offered_cost  = COST_BITS'(cost);
      it.cost_known    = known;
      it.load_next_hop = ID_BITS'(hop);
      it.last_element  = last;
      return it;
   endfunction

   function automatic dvr_item_type element_item(int snd, int dst, int cost, bit known,
                                                 bit last);
      dvr_item_type it;
      it.kind          = REQ_ELEMENT;
      it.sender        = ID_BITS'(snd);
      it.dest_index    = ID_BITS'(dst);
      it.offered_cost  = COST_BITS'(cost);
      it.cost_known    = known;
      it.load_next_hop = ID_BITS'($urandom);
      it.last_element  = last;
      return it;
   endfunction

   function automatic route_report_type report(int idx, int cost, bit known, int hop, bit chg,
                                               bit last);
      route_report_type r;
      r.index   = ID_BITS'(idx);
      r.cost    = COST_BITS'(cost);
      r.known   = known;
      r.hop     = ID_BITS'(hop);
      r.changed = chg;
      r.last    = last;
      return r;
   endfunction

   function automatic int random_cost();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 16'h03FF);
         1: return $urandom_range(16'hF000, 16'hFFFF);
         2: return $urandom_range(0, 1) ? 16'hFFFF : 0;
         default: return $urandom_range(0, 16'hFFFF);
      endcase
   endfunction

   task automatic send_item(dvr_item_type it, bit typed, route_report_type want);
      route_report_type predicted;
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.req_type      <= it.kind;
      req_ch.sender        <= it.sender;
      req_ch.dest_index    <= it.dest_index;
      req_ch.offered_cost  <= it.offered_cost;
      req_ch.cost_known    <= it.cost_known;
      req_ch.load_next_hop <= it.load_next_hop;
      req_ch.last_element  <= it.last_element;
      do @(posedge clock); while (!req_ch.ready);
      predicted = relax_route(it);
      pending_reports.push_back(typed ? want : predicted);
      sent_count++;
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         int stall_left;
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      route_report_type got;
      route_report_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.out_index, rsp_ch.out_cost, rsp_ch.out_known, rsp_ch.out_next_hop,
                 rsp_ch.changed, rsp_ch.out_last};
         if (pending_reports.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected transfer: index %0d cost %h known %b hop %0d chg %b last %b",
                        got.index, got.cost, got.known, got.hop, got.changed, got.last);
         end else begin
            want = pending_reports.pop_front();
            if (got !== want) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("mismatch: want %0d %h %b %0d %b %b, got %0d %h %b %0d %b %b",
                           want.index, want.cost, want.known, want.hop, want.changed,
                           want.last, got.index, got.cost, got.known, got.hop, got.changed,
                           got.last);
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      plan_row_type     plan[$];
      route_report_type none;
      dvr_item_type     it;
      int               len;
      int               snd;
      bit               broken;
      bit               pressed;
      none    = '0;
      pressed = 1'b0;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.req_type      <= REQ_LOAD;
      req_ch.sender        <= '0;
      req_ch.dest_index    <= '0;
      req_ch.offered_cost  <= '0;
      req_ch.cost_known    <= 1'b0;
      req_ch.load_next_hop <= '0;
      req_ch.last_element  <= 1'b0;

      plan.push_back('{load_item(1, 16'h0200, 1, 1, 0), 1, report(1, 16'h0200, 1, 1, 1, 0)});
      plan.push_back('{load_item(2, 16'h1234, 0, 5, 0), 1, report(2, 0, 0, 0, 1, 0)});
      plan.push_back('{element_item(1, 3, 16'h0100, 1, 0), 0, none});
      plan.push_back('{element_item(9, 4, 16'hFFFF, 1, 0), 1, report(4, 16'hFFFF, 1, 1, 1, 0)});
      plan.push_back('{load_item(1, 16'h0001, 1, 2, 0), 1, report(1, 16'h0001, 1, 2, 1, 0)});
      plan.push_back('{element_item(1, 3, 0, 1, 1), 0, none});
      plan.push_back('{element_item(1, 3, 0, 1, 1), 0, none});
      plan.push_back('{element_item(2, 5, 0, 1, 1), 1, report(5, 0, 0, 0, 0, 1)});
      plan.push_back('{element_item(1, 6, 16'h0040, 0, 1), 1, report(6, 0, 0, 0, 0, 1)});
      plan.push_back('{element_item(1, 3, 0, 1, 1), 0, none});
      plan.push_back('{load_item(63, 16'hFFFF, 1, 63, 1),
                       1, report(63, 16'hFFFF, 1, 63, 1, 1)});
      plan.push_back('{load_item(0, 0, 1, 0, 0), 1, report(0, 0, 1, 0, 1, 0)});
      plan.push_back('{element_item(63, 0, 0, 1, 1), 0, none});
      plan.push_back('{element_item(0, 63, 0, 1, 1), 0, none});
      plan.push_back('{element_item(63, 2, 16'hFFFF, 1, 0), 0, none});
      plan.push_back('{element_item(5, 7, 16'h0005, 1, 1), 0, none});
      plan.push_back('{load_item(1, 16'hABCD, 0, 63, 1), 1, report(1, 0, 0, 0, 1, 1)});
      plan.push_back('{element_item(1, 8, 0, 1, 1), 1, report(8, 0, 0, 0, 0, 1)});

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // write every entry once so no unwritten cost or hop is ever read
      for (int n = 0; n < MAX_NODES; n++)
         send_item(load_item(n, $urandom_range(0, 16'hFFFF), 0, $urandom_range(0, 63),
                             1'($urandom_range(0, 1))), 0, none);

      foreach (plan[i])
         send_item(plan[i].item, plan[i].typed, plan[i].want);

      while (sent_count < TOTAL_ITEMS) begin
         if (sent_count >= TOTAL_ITEMS - CALM_ITEMS)
            calm = 1;
         if (!pressed && sent_count >= PRESSURE_AT) begin
            req_ch.valid <= 1'b0;
            while (pending_reports.size() != 0) @(posedge clock);
            pressed = 1'b1;
         end
         if ($urandom_range(0, 3) == 0) begin
            send_item(load_item($urandom_range(0, 63), random_cost(),
                                $urandom_range(0, 7) != 0, $urandom_range(0, 63),
                                1'($urandom_range(0, 1))), 0, none);
         end else begin
            len    = $urandom_range(1, 6);
            broken = $urandom_range(0, 9) == 0;
            snd    = $urandom_range(0, 63);
            for (int t = 0; t < 8 && !tbl_known[snd] && $urandom_range(0, 3) != 0; t++)
               snd = $urandom_range(0, 63);
            for (int e = 0; e < len; e++) begin
               it = element_item((e == 0 || $urandom_range(0, 3) == 0) ?
                                 snd : $urandom_range(0, 63),
                                 $urandom_range(0, 63), random_cost(),
                                 $urandom_range(0, 7) != 0, (e == len - 1) && !broken);
               if ($urandom_range(0, 11) == 0)
                  send_item(load_item($urandom_range(0, 63), random_cost(),
                                      1'($urandom_range(0, 1)), $urandom_range(0, 63),
                                      1'($urandom_range(0, 1))), 0, none);
               send_item(it, 0, none);
            end
         end
      end
      req_ch.valid <= 1'b0;

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
